// ----- rtl/core/blk2_pkg.sv -----
// shared types, constants and helper functions of the blake2b hash engine
`timescale 1ns / 1ps

package blk2_pkg;

	localparam int BLOCK_BYTES = 128;
	localparam int BLOCK_WORDS = BLOCK_BYTES / 8;
	localparam int ROUNDS      = 12;
	localparam int STEPS       = 16;
	localparam int SIGMA_ROWS  = 10;

	localparam logic [6:0] DIGEST_RST = 7'd64;
	localparam logic [6:0] KEY_RST    = 7'd0;

	localparam logic [63:0] PARAM_BASE = 64'h0000_0000_0101_0000;
	localparam logic [63:0] FINAL_FLAG = 64'hFFFF_FFFF_FFFF_FFFF;

	localparam logic [63:0] IV [0:7] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
		64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [3:0] SIGMA [0:9][0:15] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		  4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
		'{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
		  4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
		'{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
		  4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
		'{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
		  4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
		'{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
		  4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
		'{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
		  4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
		'{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
		  4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
		'{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
		  4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
		'{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
		  4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
		'{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
		  4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
	};

	typedef struct packed {
		logic [63:0] data_word;
		logic [3:0]  byte_count;
		logic        last_word;
	} in_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [2:0]  word_index;
		logic        last_digest;
	} out_t;

	// controller to datapath
	typedef struct packed {
		logic       latch;
		logic       merge;
		logic       pad;
		logic       load;
		logic       round;
		logic       finish;
		logic       final_blk;
		logic [3:0] step;
		logic [3:0] rd_addr;
		logic       emit;
		logic [2:0] oidx;
		logic       init;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       full;
		logic       cnt_nz;
		logic       stage_nz;
		logic       last;
		logic [2:0] nlast;
		logic       out_free;
	} stat_t;

	function automatic logic [6:0] eff_dlen(input logic [6:0] dig);
		logic [6:0] d;
		d = dig;
		if (d == 7'd0) begin
			d = 7'd1;
		end else if (d > 7'd64) begin
			d = 7'd64;
		end
		return d;
	endfunction

	function automatic logic [63:0] param_word(input logic [6:0] dig, input logic [6:0] key);
		logic [6:0] k;
		k = (key > 7'd64) ? 7'd64 : key;
		return PARAM_BASE | {49'b0, k, 8'b0} | {57'b0, eff_dlen(dig)};
	endfunction

endpackage

// ----- rtl/core/blk2_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module blk2_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/blk2_ctrl.sv -----
// sequencing state machine of the blake2b hash engine
`timescale 1ns / 1ps

module blk2_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  blk2_pkg::stat_t stat,
	output blk2_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CHK    = 4'd1;
	localparam logic [3:0] S_MERGE  = 4'd2;
	localparam logic [3:0] S_POST   = 4'd3;
	localparam logic [3:0] S_FIN    = 4'd4;
	localparam logic [3:0] S_LOAD   = 4'd5;
	localparam logic [3:0] S_RND    = 4'd6;
	localparam logic [3:0] S_FINISH = 4'd7;
	localparam logic [3:0] S_OUT    = 4'd8;

	logic [3:0] state_q, state_d;
	logic       ret_q, ret_d;
	logic       fin_q, fin_d;
	logic [3:0] step_q, step_d;
	logic [3:0] rnd_q, rnd_d;
	logic [3:0] rsel_q, rsel_d;
	logic [2:0] oidx_q, oidx_d;
	logic [3:0] rsel_nx;
	logic [3:0] step_nx;

	assign in_ready = (state_q == S_IDLE);
	assign step_nx  = step_q + 4'd1;

	always_comb begin
		rsel_nx = rsel_q;
		if (step_q == 4'(blk2_pkg::STEPS - 1)) begin
			rsel_nx = (rsel_q == 4'(blk2_pkg::SIGMA_ROWS - 1)) ? 4'd0 : rsel_q + 4'd1;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		ret_d   = ret_q;
		fin_d   = fin_q;
		step_d  = step_q;
		rnd_d   = rnd_q;
		rsel_d  = rsel_q;
		oidx_d  = oidx_q;
		cmd.step      = step_q;
		cmd.oidx      = oidx_q;
		cmd.final_blk = fin_q;
		case (state_q)
			S_IDLE: begin
				cmd.latch = in_valid;
				if (in_valid) begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				// full block held and more bytes coming: compress it first
				if (stat.full && stat.cnt_nz) begin
					fin_d   = 1'b0;
					ret_d   = 1'b0;
					state_d = S_LOAD;
				end else begin
					state_d = S_MERGE;
				end
			end
			S_MERGE: begin
				cmd.merge = 1'b1;
				state_d   = S_POST;
			end
			S_POST: begin
				// block filled up mid-word, spill bytes still in stage
				if (stat.full && stat.stage_nz) begin
					fin_d   = 1'b0;
					ret_d   = 1'b1;
					state_d = S_LOAD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.last) begin
					cmd.pad = 1'b1;
					fin_d   = 1'b1;
					state_d = S_LOAD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_LOAD: begin
				cmd.load    = 1'b1;
				cmd.rd_addr = blk2_pkg::SIGMA[0][0];
				step_d      = 4'd0;
				rnd_d       = 4'd0;
				rsel_d      = 4'd0;
				state_d     = S_RND;
			end
			S_RND: begin
				cmd.round   = 1'b1;
				cmd.rd_addr = blk2_pkg::SIGMA[rsel_nx][step_nx];
				step_d      = step_nx;
				if (step_q == 4'(blk2_pkg::STEPS - 1)) begin
					rsel_d = rsel_nx;
					rnd_d  = rnd_q + 4'd1;
					if (rnd_q == 4'(blk2_pkg::ROUNDS - 1)) begin
						state_d = S_FINISH;
					end
				end
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				oidx_d     = 3'd0;
				if (fin_q) begin
					state_d = S_OUT;
				end else if (ret_q) begin
					state_d = S_FIN;
				end else begin
					state_d = S_MERGE;
				end
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (oidx_q == stat.nlast) begin
						cmd.init = 1'b1;
						state_d  = S_IDLE;
					end else begin
						oidx_d = oidx_q + 3'd1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= 1'b0;
			fin_q   <= 1'b0;
			step_q  <= 4'd0;
			rnd_q   <= 4'd0;
			rsel_q  <= 4'd0;
			oidx_q  <= 3'd0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			fin_q   <= fin_d;
			step_q  <= step_d;
			rnd_q   <= rnd_d;
			rsel_q  <= rsel_d;
			oidx_q  <= oidx_d;
		end
	end

endmodule

// ----- rtl/core/blk2_datapath.sv -----
// datapath: block buffer, byte packing, compression, digest output and registers
`timescale 1ns / 1ps

module blk2_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  blk2_pkg::cmd_t  cmd,
	output blk2_pkg::stat_t stat,
	input  blk2_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output blk2_pkg::out_t  out_data,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata
);

	localparam logic REG_DIGEST = 1'b0;
	localparam logic REG_KEY    = 1'b1;

	logic [6:0]   dig_q, key_q, dig_nx, key_nx;
	logic         cfg_wr;
	logic [63:0]  data_q;
	logic [3:0]   cnt_q;
	logic         last_q;
	logic [63:0]  h_q [8];
	logic [63:0]  v_q [16];
	logic [127:0] t_q, t_new;
	logic [7:0]   fill_q, inc;
	logic [63:0]  stage_q;
	logic [4:0]   limit_q;
	logic [3:0]   ridx_s1;
	logic [63:0]  ram_rdata, ram_wdata, m;
	logic         ram_we;
	logic         stage_nz;
	logic [63:0]  dmask;
	logic [127:0] comb;
	logic [3:0]   byte_sum;
	logic         spill;
	logic         half;
	logic [2:0]   g;
	logic [63:0]  a1, dx, d1, c1, bx, b1;
	logic [63:0]  tmp [16];
	logic [63:0]  vr [16];
	logic [1:0]   kr [4];
	logic [6:0]   dlen, rem;
	logic [63:0]  dword, wmask;
	logic         out_valid_q;
	blk2_pkg::out_t out_q;

	assign cfg_wr = psel && penable && pwrite;
	assign dig_nx = (cfg_wr && paddr[2] == REG_DIGEST) ? pwdata[6:0] : dig_q;
	assign key_nx = (cfg_wr && paddr[2] == REG_KEY) ? pwdata[6:0] : key_q;
	assign prdata = (paddr[2] == REG_KEY) ? {25'b0, key_q} : {25'b0, dig_q};

	// byte packing into 64-bit block words
	assign stage_nz = (fill_q[2:0] != 3'd0);
	assign dmask    = cnt_q[3] ? '1 : ((64'd1 << {cnt_q[2:0], 3'b000}) - 64'd1);
	assign comb     = {64'b0, stage_q} | ({64'b0, data_q & dmask} << {fill_q[2:0], 3'b000});
	assign byte_sum = {1'b0, fill_q[2:0]} + cnt_q;
	assign spill    = byte_sum[3];

	assign ram_we    = (cmd.merge && spill) || (cmd.pad && stage_nz);
	assign ram_wdata = cmd.merge ? comb[63:0] : stage_q;

	blk2_ram #(
		.WIDTH(64),
		.DEPTH(blk2_pkg::BLOCK_WORDS)
	) u_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_q[6:3]),
		.wdata(ram_wdata),
		.raddr(cmd.rd_addr),
		.rdata(ram_rdata)
	);

	// words past the end of the final block read as zero
	assign m = ({1'b0, ridx_s1} < limit_q) ? ram_rdata : 64'd0;

	assign inc   = cmd.final_blk ? fill_q : 8'(blk2_pkg::BLOCK_BYTES);
	assign t_new = t_q + {120'b0, inc};

	// one half of the mixing function on column zero, then row rotation
	always_comb begin
		half = cmd.step[0];
		g    = cmd.step[3:1];
		a1   = v_q[0] + v_q[4] + m;
		dx   = v_q[12] ^ a1;
		d1   = half ? {dx[15:0], dx[63:16]} : {dx[31:0], dx[63:32]};
		c1   = v_q[8] + d1;
		bx   = v_q[4] ^ c1;
		b1   = half ? {bx[62:0], bx[63]} : {bx[23:0], bx[63:24]};
		tmp  = v_q;
		tmp[0]  = a1;
		tmp[4]  = b1;
		tmp[8]  = c1;
		tmp[12] = d1;
		for (int r = 0; r < 4; r++) begin
			if (!half) begin
				kr[r] = 2'd0;
			end else if (g == 3'd3) begin
				kr[r] = 2'(r + 1);
			end else if (g == 3'd7) begin
				kr[r] = 2'(1 - r);
			end else begin
				kr[r] = 2'd1;
			end
			for (int j = 0; j < 4; j++) begin
				vr[r * 4 + j] = tmp[{2'(r), 2'(2'(j) + kr[r])}];
			end
		end
	end

	// digest word with bytes past the digest length cleared
	always_comb begin
		dlen  = blk2_pkg::eff_dlen(dig_q);
		rem   = dlen - {1'b0, cmd.oidx, 3'b000};
		wmask = (rem < 7'd8) ? ((64'd1 << {rem[2:0], 3'b000}) - 64'd1) : '1;
		dword = h_q[cmd.oidx] & wmask;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
			for (int i = 0; i < 4; i++) begin
				v_q[i + 8] <= blk2_pkg::IV[i];
			end
			v_q[12] <= blk2_pkg::IV[4] ^ t_new[63:0];
			v_q[13] <= blk2_pkg::IV[5] ^ t_new[127:64];
			v_q[14] <= blk2_pkg::IV[6] ^ (cmd.final_blk ? blk2_pkg::FINAL_FLAG : 64'd0);
			v_q[15] <= blk2_pkg::IV[7];
		end else if (cmd.round) begin
			v_q <= vr;
		end
		ridx_s1 <= cmd.rd_addr;
		if (cmd.latch) begin
			data_q <= in_data.data_word;
		end
		if (cmd.emit) begin
			out_q.digest_word <= dword;
			out_q.word_index  <= cmd.oidx;
			out_q.last_digest <= (cmd.oidx == stat.nlast);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_q       <= blk2_pkg::DIGEST_RST;
			key_q       <= blk2_pkg::KEY_RST;
			cnt_q       <= 4'd0;
			last_q      <= 1'b0;
			t_q         <= '0;
			fill_q      <= 8'd0;
			stage_q     <= 64'd0;
			limit_q     <= 5'd0;
			out_valid_q <= 1'b0;
			for (int i = 1; i < 8; i++) begin
				h_q[i] <= blk2_pkg::IV[i];
			end
			h_q[0] <= blk2_pkg::IV[0] ^
				blk2_pkg::param_word(blk2_pkg::DIGEST_RST, blk2_pkg::KEY_RST);
		end else begin
			dig_q <= dig_nx;
			key_q <= key_nx;
			if (cmd.latch) begin
				cnt_q  <= (in_data.byte_count > 4'd8) ? 4'd8 : in_data.byte_count;
				last_q <= in_data.last_word;
			end
			if (cmd.merge) begin
				fill_q  <= fill_q + {4'b0, cnt_q};
				stage_q <= spill ? comb[127:64] : comb[63:0];
			end
			if (cmd.load) begin
				t_q     <= t_new;
				limit_q <= cmd.final_blk ?
					(fill_q[7:3] + {4'b0, stage_nz}) : 5'(blk2_pkg::BLOCK_WORDS);
			end
			if (cmd.finish) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[i + 8];
				end
				if (!cmd.final_blk) begin
					fill_q <= fill_q - 8'(blk2_pkg::BLOCK_BYTES);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.init || cfg_wr) begin
				for (int i = 1; i < 8; i++) begin
					h_q[i] <= blk2_pkg::IV[i];
				end
				h_q[0]  <= blk2_pkg::IV[0] ^ blk2_pkg::param_word(dig_nx, key_nx);
				t_q     <= '0;
				fill_q  <= 8'd0;
				stage_q <= 64'd0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stat.full     = fill_q[7];
	assign stat.cnt_nz   = (cnt_q != 4'd0);
	assign stat.stage_nz = stage_nz;
	assign stat.last     = last_q;
	assign stat.nlast    = 3'((dlen - 7'd1) >> 3);
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

// ----- rtl/core/blake2b_hash_engine_top.sv -----
// top level of the blake2b hash engine
`timescale 1ns / 1ps

// blake2b hash engine, one 64-bit message word per request
// input channel: in_valid/in_ready with in_data (data_word little-endian,
//   byte_count of valid low bytes, last_word ends the message)
// output channel: out_valid/out_ready with out_data, one digest word per
//   request, word_index counting up from zero, last_digest on the final one
// config: apb write of digest_bytes (addr 0) and key_bytes (addr 4) restarts
//   the hash with new parameters; only write while the engine is idle
// per word: from accept to the next in_ready the engine steps through check, pack, check and end
// per block: a compression steps through load, 12 rounds of 16 half-mixes in
//   one shared mixing unit, and the chaining update; the block buffer memory
//   delivers one message word per half-mix
// a full block is compressed only when more bytes arrive; the last word adds
//   one compression, then the digest words leave one per cycle while out_ready
//   is high
// a stalled receiver holds the digest word in the output register; the
//   engine stays in digest readout until the final digest word is placed,
//   and only then takes new words while that word waits
// reset loads the default parameters (64-byte digest, unkeyed), clears the
//   byte counter and empties the block buffer; no clearing pass is needed

module blake2b_hash_engine_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  blk2_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output blk2_pkg::out_t out_data,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	blk2_pkg::cmd_t  cmd;
	blk2_pkg::stat_t stat;

	// zero wait state config port
	assign pready = 1'b1;

	// sequencer: packing, compression rounds and digest readout
	blk2_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// state, block buffer, mixing unit and output register
	blk2_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata)
	);

endmodule

// ----- rtl/core/blk2_checker.sv -----
// port level checks of the blake2b hash engine and their binding
`timescale 1ns / 1ps

module blk2_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input blk2_pkg::out_t out_data,
	input logic           out_valid,
	input logic           out_ready
);

	// a stalled digest word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("digest word changed while stalled");

	// in_ready drops once a word request is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken on consecutive cycles");

	// the final digest word is followed by a compression, never a word at once
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.last_digest |=> !out_valid)
		else $error("digest word right after final word");

	// digest words come in order without gaps
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last_digest |=>
		!out_valid || out_data.word_index == 3'($past(out_data.word_index) + 3'd1))
		else $error("digest word index out of order");

endmodule

bind blake2b_hash_engine_top blk2_checker u_chk (.*);

// ----- sim/tb_blake2b_hash_engine_top.sv -----
// testbench of the blake2b hash engine: predicted digests checked against the block
`timescale 1ns / 1ps

class digest_scoreboard;
	blk2_pkg::out_t pending[$];
	int errors;
	logic [6:0] dig_reg;
	logic [6:0] key_reg;
	logic [63:0] h[8];
	logic [63:0] cnt_lo;
	logic [63:0] cnt_hi;
	logic [63:0] buf_w[16];
	int fill;

	function new();
		errors = 0;
		dig_reg = 7'd64;
		key_reg = 7'd0;
		foreach (buf_w[i]) buf_w[i] = '0;
		restart();
	endfunction

	function int digest_len();
		if (dig_reg == 0) return 1;
		if (dig_reg > 64) return 64;
		return dig_reg;
	endfunction

	function void restart();
		logic [6:0] k;
		k = (key_reg > 64) ? 7'd64 : key_reg;
		for (int i = 0; i < 8; i++) h[i] = blk2_pkg::IV[i];
		h[0] ^= 64'h0101_0000 | (64'(k) << 8) | 64'(digest_len());
		cnt_lo = '0;
		cnt_hi = '0;
		fill = 0;
	endfunction

	function void set_reg(int idx, logic [31:0] val);
		if (idx == 0) dig_reg = val[6:0];
		else if (idx == 1) key_reg = val[6:0];
		else return;
		restart();
	endfunction

	function logic [63:0] rotr(logic [63:0] x, int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	function void compress(bit fin, logic [63:0] inc);
		logic [63:0] v[16];
		logic [63:0] m[16];
		int a[8], b[8], c[8], d[8];
		int s;
		a = '{0, 1, 2, 3, 0, 1, 2, 3};
		b = '{4, 5, 6, 7, 5, 6, 7, 4};
		c = '{8, 9, 10, 11, 10, 11, 8, 9};
		d = '{12, 13, 14, 15, 15, 12, 13, 14};
		m = buf_w;
		cnt_lo += inc;
		if (cnt_lo < inc) cnt_hi += 1;
		for (int i = 0; i < 8; i++) begin
			v[i] = h[i];
			v[i + 8] = blk2_pkg::IV[i];
		end
		v[12] ^= cnt_lo;
		v[13] ^= cnt_hi;
		if (fin) v[14] = ~v[14];
		for (int r = 0; r < 12; r++) begin
			s = r % 10;
			for (int g = 0; g < 8; g++) begin
				v[a[g]] = v[a[g]] + v[b[g]] + m[blk2_pkg::SIGMA[s][2 * g]];
				v[d[g]] = rotr(v[d[g]] ^ v[a[g]], 32);
				v[c[g]] = v[c[g]] + v[d[g]];
				v[b[g]] = rotr(v[b[g]] ^ v[c[g]], 24);
				v[a[g]] = v[a[g]] + v[b[g]] + m[blk2_pkg::SIGMA[s][2 * g + 1]];
				v[d[g]] = rotr(v[d[g]] ^ v[a[g]], 16);
				v[c[g]] = v[c[g]] + v[d[g]];
				v[b[g]] = rotr(v[b[g]] ^ v[c[g]], 63);
			end
		end
		for (int i = 0; i < 8; i++) h[i] ^= v[i] ^ v[i + 8];
	endfunction

	function void note_request(blk2_pkg::in_t req);
		int n, dl, rem;
		blk2_pkg::out_t o;
		logic [63:0] w;
		n = (req.byte_count > 8) ? 8 : req.byte_count;
		for (int i = 0; i < n; i++) begin
			if (fill >= 128) begin
				compress(0, 64'd128);
				fill = 0;
			end
			buf_w[fill / 8][(fill % 8) * 8 +: 8] = req.data_word[8 * i +: 8];
			fill++;
		end
		if (!req.last_word) return;
		for (int i = fill; i < 128; i++) buf_w[i / 8][(i % 8) * 8 +: 8] = 8'h00;
		compress(1, 64'(fill));
		dl = digest_len();
		n = (dl + 7) / 8;
		for (int i = 0; i < n; i++) begin
			w = h[i];
			rem = dl - 8 * i;
			if (rem < 8) w &= (64'd1 << (8 * rem)) - 1;
			o.digest_word = w;
			o.word_index = 3'(i);
			o.last_digest = (i + 1 == n);
			pending.push_back(o);
		end
		restart();
	endfunction

	function void check_result(blk2_pkg::out_t got);
		blk2_pkg::out_t exp;
		if (pending.size() == 0) begin
			$error("digest word with nothing expected: %h", got);
			errors++;
			return;
		end
		exp = pending.pop_front();
		if (got.digest_word !== exp.digest_word) begin
			$error("digest_word expected %h actual %h", exp.digest_word, got.digest_word);
			errors++;
		end
		if (got.word_index !== exp.word_index) begin
			$error("word_index expected %0d actual %0d", exp.word_index, got.word_index);
			errors++;
		end
		if (got.last_digest !== exp.last_digest) begin
			$error("last_digest expected %0d actual %0d", exp.last_digest, got.last_digest);
			errors++;
		end
	endfunction
endclass

module tb_blake2b_hash_engine_top;

	localparam int REG_DIGEST = 0;
	localparam int REG_KEY    = 1;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	blk2_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	blk2_pkg::out_t out_data;
	logic psel = 0;
	logic penable = 0;
	logic pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	digest_scoreboard board;
	// receiver stall mode: 0 never stall, 1 random stalls
	int stall_mode = 1;
	// input words handed to the block so far
	int words_sent = 0;

	blake2b_hash_engine_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	// sample requests at the rising edge
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) board.note_request(in_data);
		if (arst_n && out_valid && out_ready) board.check_result(out_data);
	end

	// receiver side: ready changes at the falling edge
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_mode == 0) begin
				out_ready <= 1;
			end else begin
				g = gap_len();
				if (g > 0) begin
					out_ready <= 0;
					repeat (g) @(negedge clk);
				end
				out_ready <= 1;
			end
		end
	end

	task automatic send_word(logic [63:0] d, logic [3:0] n, logic lst, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		// valid goes low between requests, also when there is no gap
		repeat (g + 1) @(negedge clk);
		in_data <= '{data_word: d, byte_count: n, last_word: lst};
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
		@(negedge clk);
		in_valid <= 0;
	endtask

	// random 64-bit word
	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	// a message of nbytes, mostly full words with an occasional short or overlong one
	task automatic send_message(int nbytes, bit gaps);
		int left, n;
		left = nbytes;
		while (left > 8) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : 8;
			if ($urandom_range(0, 19) == 0) n = $urandom_range(9, 15);
			send_word(rnd64(), 4'(n), 0, gaps);
			left -= (n > 8) ? 8 : n;
		end
		send_word(rnd64(), 4'(left), 1, gaps);
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// apb write while idle: setup then access
	task automatic reg_write(int idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 3'(4 * idx);
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		board.set_reg(idx, val);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic reconfigure(int dig, int key);
		drain();
		reg_write(REG_DIGEST, 32'(dig));
		reg_write(REG_KEY, 32'(key));
	endtask

	initial begin
		board = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: empty message, field extremes, short words, ragged blocks
		send_word(64'h0, 4'd0, 1, 0);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1, 0);
		send_word(64'h0123_4567_89ab_cdef, 4'd15, 1, 0);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 0, 0);
		send_word(64'hA5A5_5A5A_0F0F_F0F0, 4'd5, 1, 0);
		for (int i = 0; i < 16; i++) send_word(rnd64(), 4'd8, i == 15, 0);
		send_word(rnd64(), 4'd8, 0, 0);
		send_word(64'h0, 4'd0, 1, 0);

		// digest length extremes and out-of-range values
		reconfigure(1, 0);
		send_message(20, 1);
		reconfigure(0, 0);
		send_message(8, 1);
		reconfigure(127, 127);
		send_message(9, 1);
		send_message(3, 1);

		// keyed: zero-padded key as the first full block
		reconfigure(32, 64);
		for (int i = 0; i < 16; i++) send_word(i < 8 ? rnd64() : 64'h0, 4'd8, 0, 0);
		send_message(40, 1);

		// pause the sender until all digest words are out
		drain();

		while (words_sent < 300) begin
			if ($urandom_range(0, 7) == 0) begin
				reconfigure($urandom_range(0, 127), $urandom_range(0, 127));
			end
			stall_mode = ($urandom_range(0, 5) == 0) ? 0 : 1;
			case ($urandom_range(0, 3))
				0: send_message($urandom_range(0, 8), 1);
				1: send_message($urandom_range(9, 64), 1);
				2: send_message($urandom_range(120, 136), $urandom_range(0, 1));
				default: send_message($urandom_range(0, 300), 1);
			endcase
		end
		stall_mode = 1;
		reconfigure(64, 0);
		send_message(128, 1);
		drain();

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// generous fixed watchdog
	initial begin
		#40ms;
		$display("Mismatches found");
		$finish;
	end
endmodule
